// ===== rtl/core/lavm_pkg.sv =====
// Shared types, constants and helpers for the look-at view matrix core.
// Depends on nothing; every other file in rtl/core imports it.
package lavm_pkg;

    localparam int CW     = 32;      // coordinate width of every payload field
    localparam int MW     = CW + 1;  // width of target minus eye
    localparam int QDEPTH = 2;       // job queue depth between front and back

    typedef logic signed [CW-1:0] coord_t;
    typedef logic signed [MW-1:0] diff_t;

    typedef struct packed {
        logic signed [CW-1:0] eye_x;
        logic signed [CW-1:0] eye_y;
        logic signed [CW-1:0] eye_z;
        logic signed [CW-1:0] target_x;
        logic signed [CW-1:0] target_y;
        logic signed [CW-1:0] target_z;
        logic signed [CW-1:0] up_x;
        logic signed [CW-1:0] up_y;
        logic signed [CW-1:0] up_z;
    } lavm_in_t;

    typedef struct packed {
        logic [1:0]           row_index;
        logic signed [CW-1:0] col0;
        logic signed [CW-1:0] col1;
        logic signed [CW-1:0] col2;
        logic signed [CW-1:0] col3;
        logic                 last_row;
        logic                 degenerate;
    } lavm_out_t;

    typedef struct packed {
        coord_t [2:0] eye;
        diff_t  [2:0] diff;
        coord_t [2:0] up;
        logic         degen;
    } lavm_job_t;

    typedef enum logic [2:0] {
        N_IDLE, N_SCALE, N_SQUARE, N_SQRT, N_DIV_LOAD, N_DIV, N_DONE
    } norm_state_t;

    typedef enum logic [3:0] {
        B_IDLE, B_FWD_GO, B_FWD_WAIT, B_UP_GO, B_UP_WAIT,
        B_MUL, B_ACC, B_STORE, B_OUT
    } back_state_t;

    function automatic coord_t sat_cw(input logic signed [63:0] x);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = (64'sd1 <<< (CW - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (x > hi) begin
            return hi[CW-1:0];
        end else if (x < lo) begin
            return lo[CW-1:0];
        end
        return x[CW-1:0];
    endfunction

endpackage

// ===== rtl/core/lavm_front.sv =====
// Front end: takes input transfers, forms target minus eye and flags zero vectors.
// Depends on lavm_pkg; feeds lavm_queue.
module lavm_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  lavm_pkg::lavm_in_t  s_data,
    output logic                push_valid,
    input  logic                push_ready,
    output lavm_pkg::lavm_job_t push_data
);
    import lavm_pkg::*;

    logic      fv_reg;
    lavm_job_t job_reg;
    lavm_job_t job_next;
    logic      diff_zero;
    logic      up_zero;

    always_comb begin
        job_next.eye[0]  = s_data.eye_x;
        job_next.eye[1]  = s_data.eye_y;
        job_next.eye[2]  = s_data.eye_z;
        job_next.up[0]   = s_data.up_x;
        job_next.up[1]   = s_data.up_y;
        job_next.up[2]   = s_data.up_z;
        job_next.diff[0] = MW'(s_data.target_x) - MW'(s_data.eye_x);
        job_next.diff[1] = MW'(s_data.target_y) - MW'(s_data.eye_y);
        job_next.diff[2] = MW'(s_data.target_z) - MW'(s_data.eye_z);
        diff_zero = (job_next.diff[0] == '0) && (job_next.diff[1] == '0)
                 && (job_next.diff[2] == '0);
        up_zero   = (s_data.up_x == '0) && (s_data.up_y == '0) && (s_data.up_z == '0);
        job_next.degen = diff_zero || up_zero;
    end

    assign s_ready    = !fv_reg || push_ready;
    assign push_valid = fv_reg;
    assign push_data  = job_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fv_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            fv_reg <= 1'b1;
        end else if (push_ready) begin
            fv_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            job_reg <= job_next;
        end
    end

endmodule

// ===== rtl/core/lavm_queue.sv =====
// Short job queue between the front end and the back end.
// Depends on lavm_pkg for the job type and depth.
module lavm_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push_valid,
    output logic                push_ready,
    input  lavm_pkg::lavm_job_t push_data,
    output logic                pop_valid,
    input  logic                pop_ready,
    output lavm_pkg::lavm_job_t pop_data
);
    import lavm_pkg::*;

    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_W = $clog2(QDEPTH + 1);

    lavm_job_t          mem_reg [QDEPTH];
    logic [PW-1:0]      wr_ptr_reg;
    logic [PW-1:0]      rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (count_reg != CNT_W'(QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/core/lavm_norm.sv =====
// Iterative vector normaliser: power-of-two scaling, square sum, bit-pair
// square root and restoring division per component. Depends on lavm_pkg.
module lavm_norm #(
    parameter int FRAC_BITS = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  lavm_pkg::diff_t [2:0]     vec,
    output logic                      done,
    output logic [2:0][FRAC_BITS+2:0] unit_vec
);
    import lavm_pkg::*;

    localparam int F     = FRAC_BITS;
    localparam int QB    = F + 2;          // quotient bits
    localparam int NOW   = F + 3;          // signed result width
    localparam int LW    = 32;             // square root result width
    localparam int RW    = LW + 1;         // division remainder width
    localparam int DW    = 31 + F;         // dividend width
    localparam int SQW   = 63;             // square root working width
    localparam int CNTW  = $clog2(QB + 1);

    norm_state_t       state_reg, state_next;
    logic [MW-1:0]     mag_reg [3];
    logic [MW-1:0]     mmax_reg;
    logic [2:0]        neg_reg;
    logic [SQW-1:0]    sum_reg;
    logic [SQW-1:0]    rad_reg;
    logic [SQW-1:0]    root_reg;
    logic [SQW-1:0]    bit_reg;
    logic [1:0]        k_reg;
    logic [RW-1:0]     rem_reg;
    logic [QB-1:0]     dl_reg;
    logic [QB-1:0]     quo_reg;
    logic [CNTW-1:0]   cnt_reg;
    logic [NOW-1:0]    out_reg [3];

    logic [MW-1:0]     abs_v [3];
    logic [MW-1:0]     max_v;
    logic [59:0]       sq;
    logic [63:0]       trial_sqrt;
    logic [DW-1:0]     dividend;
    logic [RW-1:0]     trial_div;
    logic [RW-1:0]     len_ext;
    logic              ge;
    logic [QB-1:0]     quo_next;
    logic              in_range;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            abs_v[i] = vec[i][MW-1] ? MW'(-vec[i]) : MW'(vec[i]);
        end
        max_v = abs_v[0];
        if (abs_v[1] > max_v) max_v = abs_v[1];
        if (abs_v[2] > max_v) max_v = abs_v[2];
        in_range   = (mmax_reg[MW-1:30] == '0) && mmax_reg[29];
        sq         = mag_reg[k_reg][29:0] * mag_reg[k_reg][29:0];
        trial_sqrt = 64'(root_reg) + 64'(bit_reg);
        dividend   = DW'({mag_reg[k_reg][29:0], {F{1'b0}}}) + DW'(root_reg[LW-1:1]);
        len_ext    = RW'(root_reg[LW-1:0]);
        trial_div  = {rem_reg[RW-2:0], dl_reg[QB-1]};
        ge         = (trial_div >= len_ext);
        quo_next   = {quo_reg[QB-2:0], ge};
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            N_IDLE:     if (start) state_next = N_SCALE;
            N_SCALE:    if (in_range) state_next = N_SQUARE;
            N_SQUARE:   if (k_reg == 2'd2) state_next = N_SQRT;
            N_SQRT:     if (bit_reg == '0) state_next = N_DIV_LOAD;
            N_DIV_LOAD: state_next = N_DIV;
            N_DIV: begin
                if (cnt_reg == CNTW'(QB - 1)) begin
                    state_next = (k_reg == 2'd2) ? N_DONE : N_DIV_LOAD;
                end
            end
            N_DONE:     state_next = N_IDLE;
            default:    state_next = N_IDLE;
        endcase
    end

    always_comb begin
        done = (state_reg == N_DONE);
        for (int i = 0; i < 3; i++) begin
            unit_vec[i] = out_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= N_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            N_IDLE: begin
                if (start) begin
                    for (int i = 0; i < 3; i++) begin
                        mag_reg[i] <= abs_v[i];
                        neg_reg[i] <= vec[i][MW-1];
                    end
                    mmax_reg <= max_v;
                    sum_reg  <= '0;
                    k_reg    <= '0;
                end
            end
            N_SCALE: begin
                // truncate on the way down, exact on the way up
                if (mmax_reg[MW-1:30] != '0) begin
                    for (int i = 0; i < 3; i++) mag_reg[i] <= mag_reg[i] >> 1;
                    mmax_reg <= mmax_reg >> 1;
                end else if (!mmax_reg[29]) begin
                    for (int i = 0; i < 3; i++) mag_reg[i] <= mag_reg[i] << 1;
                    mmax_reg <= mmax_reg << 1;
                end
            end
            N_SQUARE: begin
                if (k_reg == 2'd2) begin
                    rad_reg  <= sum_reg + SQW'(sq);
                    root_reg <= '0;
                    bit_reg  <= SQW'(1) << 62;
                    k_reg    <= '0;
                end else begin
                    sum_reg <= sum_reg + SQW'(sq);
                    k_reg   <= k_reg + 1'b1;
                end
            end
            N_SQRT: begin
                if (bit_reg != '0) begin
                    if (64'(rad_reg) >= trial_sqrt) begin
                        rad_reg  <= rad_reg - trial_sqrt[SQW-1:0];
                        root_reg <= (root_reg >> 1) + bit_reg;
                    end else begin
                        root_reg <= root_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                end
            end
            N_DIV_LOAD: begin
                rem_reg <= RW'(dividend[DW-1:QB]);
                dl_reg  <= dividend[QB-1:0];
                quo_reg <= '0;
                cnt_reg <= '0;
            end
            N_DIV: begin
                rem_reg <= ge ? trial_div - len_ext : trial_div;
                dl_reg  <= dl_reg << 1;
                quo_reg <= quo_next;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNTW'(QB - 1)) begin
                    out_reg[k_reg] <= neg_reg[k_reg] ? -NOW'(quo_next) : NOW'(quo_next);
                    k_reg <= k_reg + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== rtl/core/lavm_back.sv =====
// Back end: runs both normalisations in turn on one lavm_norm, then the
// cross and eye dot products on one multiplier, and hands out four row
// transfers. Depends on lavm_pkg and lavm_norm.
module lavm_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                job_valid,
    output logic                job_ready,
    input  lavm_pkg::lavm_job_t job,
    output logic                m_valid,
    input  logic                m_ready,
    output lavm_pkg::lavm_out_t m_data
);
    import lavm_pkg::*;

    localparam int F   = FRAC_BITS;
    localparam int NOW = F + 3;
    localparam int MA  = F + 4;
    localparam int MB  = (CW > F + 4) ? CW : F + 4;
    localparam int PW  = MA + MB;
    localparam int AW  = PW + 2;

    back_state_t            state_reg, state_next;
    lavm_job_t              job_reg;
    logic signed [NOW-1:0]  fwd_reg  [3];
    logic signed [NOW-1:0]  upn_reg  [3];
    logic signed [MA-1:0]   left_reg [3];
    logic signed [MA-1:0]   tup_reg  [3];
    coord_t                 col3_reg [3];
    logic [3:0]             grp_reg;
    logic [1:0]             term_reg;
    logic signed [PW-1:0]   prod_reg;
    logic                   sub_reg;
    logic signed [AW-1:0]   acc_reg;
    logic [1:0]             row_reg;

    logic                   norm_start;
    logic                   norm_done;
    diff_t [2:0]            norm_vec;
    logic [2:0][NOW-1:0]    norm_out;

    logic [1:0]             gj, j1, j2;
    logic                   is_cross;
    logic                   last_term;
    logic signed [MA-1:0]   a_op;
    logic signed [MB-1:0]   b_op;
    logic                   sub_op;
    logic signed [63:0]     rounded;

    lavm_norm #(.FRAC_BITS(FRAC_BITS)) u_norm (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (norm_start),
        .vec      (norm_vec),
        .done     (norm_done),
        .unit_vec (norm_out)
    );

    // operand selection for the current term
    always_comb begin
        if (grp_reg < 4'd3) begin
            gj = grp_reg[1:0];
        end else if (grp_reg < 4'd6) begin
            gj = 2'(grp_reg - 4'd3);
        end else begin
            gj = 2'(grp_reg - 4'd6);
        end
        j1 = (gj == 2'd2) ? 2'd0 : gj + 2'd1;
        j2 = (gj == 2'd0) ? 2'd2 : gj - 2'd1;
        is_cross  = (grp_reg < 4'd6);
        last_term = is_cross ? (term_reg == 2'd1) : (term_reg == 2'd2);
        sub_op    = is_cross && term_reg[0];
        if (grp_reg < 4'd3) begin
            a_op = term_reg[0] ? MA'(fwd_reg[j2]) : MA'(fwd_reg[j1]);
            b_op = term_reg[0] ? MB'(upn_reg[j1]) : MB'(upn_reg[j2]);
        end else if (grp_reg < 4'd6) begin
            a_op = term_reg[0] ? left_reg[j2] : left_reg[j1];
            b_op = term_reg[0] ? MB'(fwd_reg[j1]) : MB'(fwd_reg[j2]);
        end else begin
            case (gj)
                2'd0:    a_op = left_reg[term_reg];
                2'd1:    a_op = tup_reg[term_reg];
                default: a_op = -MA'(fwd_reg[term_reg]);
            endcase
            b_op = MB'($signed(job_reg.eye[term_reg]));
        end
        rounded = (64'(acc_reg) + (64'sd1 <<< (F - 1))) >>> F;
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            norm_vec[i] = (state_reg == B_FWD_GO) ? job_reg.diff[i]
                                                  : MW'($signed(job_reg.up[i]));
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE: begin
                if (job_valid) state_next = job.degen ? B_OUT : B_FWD_GO;
            end
            B_FWD_GO:   state_next = B_FWD_WAIT;
            B_FWD_WAIT: if (norm_done) state_next = B_UP_GO;
            B_UP_GO:    state_next = B_UP_WAIT;
            B_UP_WAIT:  if (norm_done) state_next = B_MUL;
            B_MUL:      state_next = B_ACC;
            B_ACC:      state_next = last_term ? B_STORE : B_MUL;
            B_STORE:    state_next = (grp_reg == 4'd8) ? B_OUT : B_MUL;
            B_OUT: begin
                if (m_ready && row_reg == 2'd3) state_next = B_IDLE;
            end
            default:    state_next = B_IDLE;
        endcase
    end

    always_comb begin
        job_ready  = (state_reg == B_IDLE);
        norm_start = (state_reg == B_FWD_GO) || (state_reg == B_UP_GO);
        m_valid    = (state_reg == B_OUT);
        m_data.row_index  = row_reg;
        m_data.last_row   = (row_reg == 2'd3);
        m_data.degenerate = job_reg.degen;
        case (row_reg)
            2'd0: begin
                m_data.col0 = sat_cw(64'(left_reg[0]));
                m_data.col1 = sat_cw(64'(left_reg[1]));
                m_data.col2 = sat_cw(64'(left_reg[2]));
                m_data.col3 = col3_reg[0];
            end
            2'd1: begin
                m_data.col0 = sat_cw(64'(tup_reg[0]));
                m_data.col1 = sat_cw(64'(tup_reg[1]));
                m_data.col2 = sat_cw(64'(tup_reg[2]));
                m_data.col3 = col3_reg[1];
            end
            2'd2: begin
                m_data.col0 = sat_cw(-64'(fwd_reg[0]));
                m_data.col1 = sat_cw(-64'(fwd_reg[1]));
                m_data.col2 = sat_cw(-64'(fwd_reg[2]));
                m_data.col3 = col3_reg[2];
            end
            default: begin
                m_data.col0 = '0;
                m_data.col1 = '0;
                m_data.col2 = '0;
                m_data.col3 = sat_cw(64'sd1 <<< F);
            end
        endcase
        if (job_reg.degen) begin
            m_data.col0 = '0;
            m_data.col1 = '0;
            m_data.col2 = '0;
            m_data.col3 = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            B_IDLE: begin
                if (job_valid) begin
                    job_reg <= job;
                    row_reg <= '0;
                end
            end
            B_FWD_WAIT: begin
                if (norm_done) begin
                    for (int i = 0; i < 3; i++) fwd_reg[i] <= $signed(norm_out[i]);
                end
            end
            B_UP_WAIT: begin
                if (norm_done) begin
                    for (int i = 0; i < 3; i++) upn_reg[i] <= $signed(norm_out[i]);
                    grp_reg  <= '0;
                    term_reg <= '0;
                    acc_reg  <= '0;
                end
            end
            B_MUL: begin
                prod_reg <= a_op * b_op;
                sub_reg  <= sub_op;
            end
            B_ACC: begin
                acc_reg <= sub_reg ? acc_reg - AW'(prod_reg) : acc_reg + AW'(prod_reg);
                if (!last_term) term_reg <= term_reg + 2'd1;
            end
            B_STORE: begin
                if (grp_reg < 4'd3) begin
                    left_reg[gj] <= MA'(rounded);
                end else if (grp_reg < 4'd6) begin
                    tup_reg[gj] <= MA'(rounded);
                end else begin
                    col3_reg[gj] <= sat_cw(-rounded);
                end
                acc_reg  <= '0;
                term_reg <= '0;
                grp_reg  <= grp_reg + 4'd1;
                row_reg  <= '0;
            end
            B_OUT: begin
                if (m_ready) row_reg <= row_reg + 2'd1;
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== rtl/core/look_at_view_matrix_core.sv =====
// Look-at view matrix core: front end, job queue and back end.
// Depends on lavm_pkg, lavm_front, lavm_queue and lavm_back.
//
// Usage:
//   s_valid/s_ready/s_data carry one camera description per transfer: eye,
//   target and approximate up, signed fixed point with FRAC_BITS fraction bits.
//   m_valid/m_ready/m_data return the view matrix as four row transfers,
//   rows 0 to 3 in order, last_row marking row 3 and degenerate set on all
//   four when forward or up has zero length (entries are then zero).
// Flow:
//   A normal item goes from acceptance through the iterative normaliser
//   (1 to 30 scaling steps, a 32-step square root and a FRAC_BITS+2 step
//   division per component, run for forward and for up) and then through
//   the shared multiplier for the cross and dot products before its first
//   row. A degenerate item passes the front register and the queue and goes
//   straight to the row output. Four row transfers follow at one per cycle
//   while the receiver does not stall, and the back end takes no new item
//   until its last row is taken.
//   The front register and the two-entry queue take further items while the
//   back end works, so the input stalls only once three items wait.
// Reset clears all handshake state; no clearing pass is needed. A stalled
// receiver holds the current row steady and the back end waits for it.
module look_at_view_matrix_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  lavm_pkg::lavm_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output lavm_pkg::lavm_out_t m_data
);
    import lavm_pkg::*;

    logic      push_valid;
    logic      push_ready;
    lavm_job_t push_data;
    logic      pop_valid;
    logic      pop_ready;
    lavm_job_t pop_data;

    lavm_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    lavm_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    lavm_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (pop_valid),
        .job_ready (pop_ready),
        .job       (pop_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
